// ===== src/hbdp_pkg.sv =====
package hbdp_pkg;

  // Result queue between the last pipeline stage and the master port.
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = 2;
  localparam int OUTQ_CW    = 3;

  // Input transfer layout: pc, target, outcome, zero padding to whole bytes.
  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 8;

  // Entry of the table indexed by the global history: the GAg counter and
  // the three chooser counters live side by side.
  typedef struct packed {
    logic [2:0] glb;
    logic [1:0] clg;
    logic [1:0] cxl;
    logic [1:0] cxg;
  } gsel_t;

  // Everything the training logic needs for one branch.
  typedef struct packed {
    logic [1:0] bim;
    logic [1:0] loc;
    logic [2:0] xr;
    gsel_t      gs;
    logic       taken;
    logic       stat;
  } trn_in_t;

  // New table contents produced by the training logic.
  typedef struct packed {
    logic [1:0] bim;
    logic [1:0] loc;
    logic [2:0] xr;
    gsel_t      gs;
  } trn_upd_t;

  // Prediction bits, static guess in the lowest bit.
  typedef struct packed {
    logic tour;
    logic major;
    logic choice;
    logic xorg;
    logic glb;
    logic loc;
    logic bim;
    logic stat;
  } pred_t;

  // Two-bit signed saturating counter, range -2..1.
  function automatic logic [1:0] sat_step2(logic [1:0] v, logic up);
    logic [1:0] r;
    if (up) begin
      r = (v == 2'b01) ? v : v + 2'd1;
    end else begin
      r = (v == 2'b10) ? v : v - 2'd1;
    end
    return r;
  endfunction

  // Three-bit signed saturating counter, range -4..3.
  function automatic logic [2:0] sat_step3(logic [2:0] v, logic up);
    logic [2:0] r;
    if (up) begin
      r = (v == 3'b011) ? v : v + 3'd1;
    end else begin
      r = (v == 3'b100) ? v : v - 3'd1;
    end
    return r;
  endfunction

  // Chooser moves toward the first component when only it was right, toward
  // the second when only that one was right, and holds otherwise.
  function automatic logic [1:0] chooser_step(logic [1:0] v, logic first_ok, logic second_ok);
    logic [1:0] r;
    if (first_ok == second_ok) begin
      r = v;
    end else begin
      r = sat_step2(v, first_ok);
    end
    return r;
  endfunction

endpackage

// ===== src/hbdp_ram.sv =====
module hbdp_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 2
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;
  logic [WIDTH-1:0] fwd_q;
  logic             hit_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
      fwd_q   <= wdata_i;
    end
  end

  // A read that meets a write to the same entry at the same edge would see
  // the old contents; the written word is passed on instead.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (re_i) begin
      hit_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = hit_q ? fwd_q : rdata_q;

endmodule

// ===== src/hbdp_train.sv =====
module hbdp_train (
  input  hbdp_pkg::trn_in_t  trn_i,
  output hbdp_pkg::pred_t    pred_o,
  output hbdp_pkg::trn_upd_t upd_o
);

  logic p_loc, p_glb, p_xor, lg_local;
  logic loc_ok, glb_ok, xor_ok;

  // A counter predicts taken when it is non-negative.
  assign p_loc    = ~trn_i.loc[1];
  assign p_glb    = ~trn_i.gs.glb[2];
  assign p_xor    = ~trn_i.xr[2];
  assign lg_local = ~trn_i.gs.clg[1];

  assign loc_ok = (p_loc == trn_i.taken);
  assign glb_ok = (p_glb == trn_i.taken);
  assign xor_ok = (p_xor == trn_i.taken);

  always_comb begin
    pred_o.stat   = trn_i.stat;
    pred_o.bim    = ~trn_i.bim[1];
    pred_o.loc    = p_loc;
    pred_o.glb    = p_glb;
    pred_o.xorg   = p_xor;
    pred_o.choice = lg_local ? p_loc : p_glb;
    pred_o.major  = (p_loc & p_glb) | (p_loc & p_xor) | (p_glb & p_xor);
    if (lg_local) begin
      pred_o.tour = (~trn_i.gs.cxl[1]) ? p_xor : p_loc;
    end else begin
      pred_o.tour = (~trn_i.gs.cxg[1]) ? p_xor : p_glb;
    end
  end

  always_comb begin
    upd_o.bim    = hbdp_pkg::sat_step2(trn_i.bim, trn_i.taken);
    upd_o.loc    = hbdp_pkg::sat_step2(trn_i.loc, trn_i.taken);
    upd_o.xr     = hbdp_pkg::sat_step3(trn_i.xr, trn_i.taken);
    upd_o.gs.glb = hbdp_pkg::sat_step3(trn_i.gs.glb, trn_i.taken);
    upd_o.gs.clg = hbdp_pkg::chooser_step(trn_i.gs.clg, loc_ok, glb_ok);
    upd_o.gs.cxl = hbdp_pkg::chooser_step(trn_i.gs.cxl, xor_ok, loc_ok);
    upd_o.gs.cxg = hbdp_pkg::chooser_step(trn_i.gs.cxg, xor_ok, glb_ok);
  end

endmodule

// ===== src/hbdp_outq.sv =====
module hbdp_outq (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  hbdp_pkg::pred_t                 push_data_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output hbdp_pkg::pred_t                 data_o,
  output logic [hbdp_pkg::OUTQ_CW-1:0]    count_o
);

  hbdp_pkg::pred_t                entry_q [hbdp_pkg::OUTQ_DEPTH];
  logic [hbdp_pkg::OUTQ_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [hbdp_pkg::OUTQ_CW-1:0]   count_q, count_d;
  logic                           pop;

  assign valid_o = (count_q != '0);
  assign pop     = valid_o && ready_i;
  assign data_o  = entry_q[rd_ptr_q];
  assign count_o = count_q;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

endmodule

// ===== src/hybrid_branch_direction_predictor_core.sv =====
// Channel   Dir  Width  Contents (lowest bit first)
// s_axis    in   136    branch_pc[63:0], branch_target[127:64], was_taken[128], zero pad
// m_axis    out  8      pred_static, pred_bimodal, pred_local, pred_global,
//                       pred_xor_global, pred_local_global_choice, pred_majority,
//                       pred_tournament
//
// One branch is taken per cycle while s_axis_tready is high. A result passes
// stage 1, stage 2 and the result queue before it is offered on m_axis. The
// local history memory is read in the first stage and its word addresses the
// local counter memory in the second. After reset a clearing pass zeroes every
// table, one entry a cycle, through max(LOCAL_TABLE_ENTRIES, PHT_ENTRIES) entries;
// s_axis_tready stays low meanwhile. A four-entry result queue absorbs master-side
// stalls; besides the clearing pass, s_axis_tready drops only when the queue and
// the two stages in flight would fill it.
module hybrid_branch_direction_predictor_core #(
  parameter int HISTORY_BITS        = 9,
  parameter int LOCAL_TABLE_ENTRIES = 1024,
  parameter int PHT_ENTRIES         = 512
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // branch_pc [63:0], branch_target [127:64], was_taken [128], zeros above
  input  logic [hbdp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // pred_static [0], pred_bimodal [1], pred_local [2], pred_global [3],
  // pred_xor_global [4], pred_local_global_choice [5], pred_majority [6],
  // pred_tournament [7]
  output logic [hbdp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  // Table sizes must be powers of two, not checked here; each index is a low-bit field.
  localparam int LI_W = $clog2(LOCAL_TABLE_ENTRIES);
  localparam int PI_W = $clog2(PHT_ENTRIES);
  localparam int MAXD = (LOCAL_TABLE_ENTRIES > PHT_ENTRIES) ? LOCAL_TABLE_ENTRIES
                                                            : PHT_ENTRIES;
  localparam int CW   = $clog2(MAXD);

  // ---------------------------------------------------------------------------
  // Clearing pass after reset.
  // ---------------------------------------------------------------------------
  logic          busy_q;
  logic [CW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      clr_cnt_q <= '0;
    end else if (busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == CW'(MAXD - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: transfer. The global history is a register and moves on at once;
  // the local history of this pc is read from its memory.
  // ---------------------------------------------------------------------------
  logic                    accept;
  logic [63:0]             in_pc, in_target;
  logic                    in_taken;
  logic [HISTORY_BITS-1:0] ghist_q;
  logic [PI_W-1:0]         bi0, gi0, xi0;
  logic [LI_W-1:0]         li0;
  logic [hbdp_pkg::OUTQ_CW-1:0] q_count, pending;

  logic                    v1_q, v2_q;

  assign in_pc     = s_axis_tdata[63:0];
  assign in_target = s_axis_tdata[127:64];
  assign in_taken  = s_axis_tdata[128];

  // Results that will land in the queue: those in it plus the two stages.
  assign pending = q_count + hbdp_pkg::OUTQ_CW'(v1_q) + hbdp_pkg::OUTQ_CW'(v2_q);
  assign s_axis_tready = !busy_q && (pending < hbdp_pkg::OUTQ_CW'(hbdp_pkg::OUTQ_DEPTH));
  assign accept = s_axis_tvalid && s_axis_tready;

  assign bi0 = in_pc[PI_W-1:0];
  assign li0 = in_pc[LI_W-1:0];
  assign xi0 = bi0 ^ gi0;

  // Local counter index from the local history word, used in stage 1.
  logic [HISTORY_BITS-1:0] lh_rdata;
  logic [PI_W-1:0]         lci1;

  if (HISTORY_BITS >= PI_W) begin : g_hist_trunc
    assign gi0  = ghist_q[PI_W-1:0];
    assign lci1 = lh_rdata[PI_W-1:0];
  end else begin : g_hist_ext
    assign gi0  = {{(PI_W - HISTORY_BITS){1'b0}}, ghist_q};
    assign lci1 = {{(PI_W - HISTORY_BITS){1'b0}}, lh_rdata};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ghist_q <= '0;
    end else if (accept) begin
      ghist_q <= {ghist_q[HISTORY_BITS-2:0], in_taken};
    end
  end

  logic [LI_W-1:0] li1_q;
  logic [PI_W-1:0] bi1_q, gi1_q, xi1_q;
  logic            taken1_q, stat1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      li1_q    <= li0;
      bi1_q    <= bi0;
      gi1_q    <= gi0;
      xi1_q    <= xi0;
      taken1_q <= in_taken;
      stat1_q  <= (in_pc > in_target);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: local history is back. It is shifted and written back, and it
  // addresses the local counters while the other counter tables are read.
  // ---------------------------------------------------------------------------
  logic                    lh_we;
  logic [LI_W-1:0]         lh_waddr;
  logic [HISTORY_BITS-1:0] lh_wdata;

  assign lh_we    = busy_q || v1_q;
  assign lh_waddr = busy_q ? clr_cnt_q[LI_W-1:0] : li1_q;
  assign lh_wdata = busy_q ? '0 : {lh_rdata[HISTORY_BITS-2:0], taken1_q};

  hbdp_ram #(
    .DEPTH (LOCAL_TABLE_ENTRIES),
    .WIDTH (HISTORY_BITS)
  ) u_lhist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (lh_we),
    .waddr_i (lh_waddr),
    .wdata_i (lh_wdata),
    .re_i    (accept),
    .raddr_i (li0),
    .rdata_o (lh_rdata)
  );

  logic [PI_W-1:0] bi2_q, lci2_q, gi2_q, xi2_q;
  logic            taken2_q, stat2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      bi2_q    <= bi1_q;
      lci2_q   <= lci1;
      gi2_q    <= gi1_q;
      xi2_q    <= xi1_q;
      taken2_q <= taken1_q;
      stat2_q  <= stat1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: counters are back. Predictions go to the result queue and the
  // trained counters are written back. A read issued by the next branch at
  // the same edge is served from the write data inside each memory.
  // ---------------------------------------------------------------------------
  hbdp_pkg::trn_in_t  trn;
  hbdp_pkg::trn_upd_t upd;
  hbdp_pkg::pred_t    pred;

  logic            pht_we;
  logic [PI_W-1:0] clr_pi;
  logic [1:0]      bim_rdata, loc_rdata;
  logic [2:0]      xr_rdata;
  hbdp_pkg::gsel_t gs_rdata;

  assign pht_we = busy_q || v2_q;
  assign clr_pi = clr_cnt_q[PI_W-1:0];

  hbdp_ram #(
    .DEPTH (PHT_ENTRIES),
    .WIDTH (2)
  ) u_bim (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (pht_we),
    .waddr_i (busy_q ? clr_pi : bi2_q),
    .wdata_i (busy_q ? 2'b00 : upd.bim),
    .re_i    (v1_q),
    .raddr_i (bi1_q),
    .rdata_o (bim_rdata)
  );

  hbdp_ram #(
    .DEPTH (PHT_ENTRIES),
    .WIDTH (2)
  ) u_loc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (pht_we),
    .waddr_i (busy_q ? clr_pi : lci2_q),
    .wdata_i (busy_q ? 2'b00 : upd.loc),
    .re_i    (v1_q),
    .raddr_i (lci1),
    .rdata_o (loc_rdata)
  );

  hbdp_ram #(
    .DEPTH (PHT_ENTRIES),
    .WIDTH (3)
  ) u_xor (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (pht_we),
    .waddr_i (busy_q ? clr_pi : xi2_q),
    .wdata_i (busy_q ? 3'b000 : upd.xr),
    .re_i    (v1_q),
    .raddr_i (xi1_q),
    .rdata_o (xr_rdata)
  );

  // GAg counters and the three choosers share the global-history index.
  hbdp_ram #(
    .DEPTH (PHT_ENTRIES),
    .WIDTH ($bits(hbdp_pkg::gsel_t))
  ) u_gsel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (pht_we),
    .waddr_i (busy_q ? clr_pi : gi2_q),
    .wdata_i (busy_q ? '0 : upd.gs),
    .re_i    (v1_q),
    .raddr_i (gi1_q),
    .rdata_o (gs_rdata)
  );

  always_comb begin
    trn.bim   = bim_rdata;
    trn.loc   = loc_rdata;
    trn.xr    = xr_rdata;
    trn.gs    = gs_rdata;
    trn.taken = taken2_q;
    trn.stat  = stat2_q;
  end

  hbdp_train u_train (
    .trn_i  (trn),
    .pred_o (pred),
    .upd_o  (upd)
  );

  // ---------------------------------------------------------------------------
  // Result queue toward the master port.
  // ---------------------------------------------------------------------------
  hbdp_pkg::pred_t q_data;

  hbdp_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (v2_q),
    .push_data_i (pred),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .data_o      (q_data),
    .count_o     (q_count)
  );

  assign m_axis_tdata = q_data;

endmodule

// ===== src/hbdp_checker.sv =====
module hbdp_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [hbdp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic       in_xfer, out_xfer;
  logic [3:0] outst_q, outst_d;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  always_comb begin
    outst_d = outst_q;
    if (in_xfer && !out_xfer) begin
      outst_d = outst_q + 4'd1;
    end else if (!in_xfer && out_xfer) begin
      outst_d = outst_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else begin
      outst_q <= outst_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> outst_q != 4'd0)
    else $error("result offered with no branch outstanding");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outst_q <= 4'(hbdp_pkg::OUTQ_DEPTH))
    else $error("more branches outstanding than the result queue holds");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && outst_q == 4'd0 |=> !m_axis_tvalid)
    else $error("result appeared too early");

endmodule

bind hybrid_branch_direction_predictor_core hbdp_checker u_hbdp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== sim/branch_prediction_monitor.sv =====
`timescale 1ns / 1ps

// Watches both stream channels of the predictor core. Each accepted branch is
// run through a local copy of the prediction tables, and the expected
// prediction byte is queued. Each accepted result is compared field by field
// with the oldest queued prediction.
module branch_prediction_monitor #(
  parameter int HIST_W   = 9,
  parameter int LHT_SIZE = 1024,
  parameter int PHT_SIZE = 512
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic [hbdp_pkg::IN_TDATA_W-1:0]     in_data_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic [hbdp_pkg::OUT_TDATA_W-1:0]    out_data_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);

  logic signed [1:0] bim_ctr     [PHT_SIZE];
  logic signed [1:0] loc_ctr     [PHT_SIZE];
  logic signed [2:0] glb_ctr     [PHT_SIZE];
  logic signed [2:0] gsh_ctr     [PHT_SIZE];
  logic signed [1:0] sel_loc_glb [PHT_SIZE];
  logic signed [1:0] sel_gsh_loc [PHT_SIZE];
  logic signed [1:0] sel_gsh_glb [PHT_SIZE];
  logic [HIST_W-1:0] loc_hist    [LHT_SIZE];
  logic [HIST_W-1:0] glb_hist;

  hbdp_pkg::pred_t expected_preds[$];
  int fail_count;
  int pending;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;

  function automatic int saturate(int v, bit up, int lo, int hi);
    if (up) begin
      return (v >= hi) ? hi : v + 1;
    end
    return (v <= lo) ? lo : v - 1;
  endfunction

  // A chooser only moves when exactly one of its two components was right;
  // it moves up when the first one was.
  function automatic int steer(int v, bit first_ok, bit second_ok);
    if (first_ok == second_ok) begin
      return v;
    end
    return saturate(v, first_ok, -2, 1);
  endfunction

  task automatic clear_tables();
    for (int i = 0; i < PHT_SIZE; i++) begin
      bim_ctr[i]     = '0;
      loc_ctr[i]     = '0;
      glb_ctr[i]     = '0;
      gsh_ctr[i]     = '0;
      sel_loc_glb[i] = '0;
      sel_gsh_loc[i] = '0;
      sel_gsh_glb[i] = '0;
    end
    for (int i = 0; i < LHT_SIZE; i++) begin
      loc_hist[i] = '0;
    end
    glb_hist = '0;
  endtask

  task automatic resolve_branch(logic [63:0] pc, logic [63:0] tgt, logic tk);
    int bi;
    int li;
    int lci;
    int gi;
    int xi;
    logic [HIST_W-1:0] lh;
    hbdp_pkg::pred_t p;
    bit loc_ok;
    bit glb_ok;
    bit gsh_ok;
    bi  = int'(pc % PHT_SIZE);
    li  = int'(pc % LHT_SIZE);
    lh  = loc_hist[li];
    lci = int'(lh) % PHT_SIZE;
    gi  = int'(glb_hist) % PHT_SIZE;
    xi  = (bi ^ int'(glb_hist)) % PHT_SIZE;

    // A counter predicts taken while its sign bit is clear.
    p.stat   = pc > tgt;
    p.bim    = ~bim_ctr[bi][1];
    p.loc    = ~loc_ctr[lci][1];
    p.glb    = ~glb_ctr[gi][2];
    p.xorg   = ~gsh_ctr[xi][2];
    p.choice = ~sel_loc_glb[gi][1] ? p.loc : p.glb;
    p.major  = (p.loc & p.glb) | (p.loc & p.xorg) | (p.glb & p.xorg);
    if (~sel_loc_glb[gi][1]) begin
      p.tour = ~sel_gsh_loc[gi][1] ? p.xorg : p.loc;
    end else begin
      p.tour = ~sel_gsh_glb[gi][1] ? p.xorg : p.glb;
    end
    expected_preds.push_back(p);

    loc_ok = (p.loc == tk);
    glb_ok = (p.glb == tk);
    gsh_ok = (p.xorg == tk);
    bim_ctr[bi]     = 2'(saturate(int'(bim_ctr[bi]), tk, -2, 1));
    loc_ctr[lci]    = 2'(saturate(int'(loc_ctr[lci]), tk, -2, 1));
    glb_ctr[gi]     = 3'(saturate(int'(glb_ctr[gi]), tk, -4, 3));
    gsh_ctr[xi]     = 3'(saturate(int'(gsh_ctr[xi]), tk, -4, 3));
    sel_loc_glb[gi] = 2'(steer(int'(sel_loc_glb[gi]), loc_ok, glb_ok));
    sel_gsh_loc[gi] = 2'(steer(int'(sel_gsh_loc[gi]), gsh_ok, loc_ok));
    sel_gsh_glb[gi] = 2'(steer(int'(sel_gsh_glb[gi]), gsh_ok, glb_ok));
    loc_hist[li]    = {lh[HIST_W-2:0], tk};
    glb_hist        = {glb_hist[HIST_W-2:0], tk};
  endtask

  task automatic compare_field(string field, logic exp_bit, logic act_bit);
    if (exp_bit !== act_bit) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("%0t: %s mismatch, expected %b, got %b", $realtime, field, exp_bit, act_bit);
      end
    end
  endtask

  task automatic check_result(hbdp_pkg::pred_t act);
    hbdp_pkg::pred_t exp_p;
    if (expected_preds.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("%0t: result transfer %h with no branch pending", $realtime, act);
      end
    end else begin
      exp_p = expected_preds.pop_front();
      compare_field("pred_static", exp_p.stat, act.stat);
      compare_field("pred_bimodal", exp_p.bim, act.bim);
      compare_field("pred_local", exp_p.loc, act.loc);
      compare_field("pred_global", exp_p.glb, act.glb);
      compare_field("pred_xor_global", exp_p.xorg, act.xorg);
      compare_field("pred_local_global_choice", exp_p.choice, act.choice);
      compare_field("pred_majority", exp_p.major, act.major);
      compare_field("pred_tournament", exp_p.tour, act.tour);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_tables();
      expected_preds.delete();
      fail_count = 0;
      pending    = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        resolve_branch(in_data_i[63:0], in_data_i[127:64], in_data_i[128]);
      end
      if (out_valid_i && out_ready_i) begin
        check_result(hbdp_pkg::pred_t'(out_data_i));
      end
      pending = expected_preds.size();
    end
  end

endmodule

// ===== sim/tb_hybrid_branch_direction_predictor_core.sv =====
`timescale 1ns / 1ps

// Top of the predictor testbench. It drives branch transfers into the core,
// paces the result side, and gives the verdict from the monitor's count of
// failures. All prediction and comparison live in the monitor.
module tb_hybrid_branch_direction_predictor_core;

  // The idle limit sits well above both the clearing pass after reset, which
  // keeps the input side stalled, and the receiver hold-off.
  localparam int IDLE_LIMIT   = 5000;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 250;
  localparam int RANDOM_ITEMS = 550;
  localparam int POOL_SIZE    = 12;
  localparam int DRAIN_CYCLES = 12;

  logic                                clk_i         = 1'b0;
  logic                                rst_ni        = 1'b0;
  logic                                s_axis_tvalid = 1'b0;
  logic                                s_axis_tready;
  // branch_pc [63:0], branch_target [127:64], was_taken [128], zeros above
  logic [hbdp_pkg::IN_TDATA_W-1:0]     s_axis_tdata  = '0;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready = 1'b0;
  // pred_static [0], pred_bimodal [1], pred_local [2], pred_global [3],
  // pred_xor_global [4], pred_local_global_choice [5], pred_majority [6],
  // pred_tournament [7]
  logic [hbdp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;

  int fail_count;
  int pending;
  int accepted_items = 0;
  int burst_left     = 0;
  int idle_cycles    = 0;
  bit hold_done      = 1'b0;

  // A small pool of recurring branches, each repeating its own outcome
  // pattern, so that the history-based tables and the choosers get trained.
  logic [63:0] pool_pc    [POOL_SIZE];
  logic [63:0] pool_tgt   [POOL_SIZE];
  logic [15:0] pool_pat   [POOL_SIZE];
  int          pool_len   [POOL_SIZE];
  int          pool_phase [POOL_SIZE];

  always #5 clk_i = ~clk_i;

  hybrid_branch_direction_predictor_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  branch_prediction_monitor u_monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // The watchdog restarts its count on every transfer on either side. A hang
  // anywhere, including an expected result that never shows up, ends here.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Offers one branch and holds it until the core takes the transfer. After
  // that a gap may follow: mostly none, sometimes a short one, rarely a long
  // one. Now and then a burst of back-to-back transfers is forced. Valid is
  // only lowered when a gap really follows, so it never drops and rises
  // within one time step.
  task automatic send_branch(logic [63:0] pc, logic [63:0] tgt, logic tk);
    int r;
    int gap;
    s_axis_tdata  <= {7'b0, tk, tgt, pc};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    accepted_items++;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        burst_left = 30;
      end
      if (r < 65) begin
        gap = 0;
      end else if (r < 92) begin
        gap = $urandom_range(1, 3);
      end else begin
        gap = $urandom_range(8, 30);
      end
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Result side. The ready line is held for random stretches, mostly high.
  // Once enough branches have gone in, it is held low for a long stretch
  // while the sender keeps going, so that the result queue fills and the
  // core has to stall its input.
  initial begin
    int r;
    int len;
    logic rdy;
    @(posedge rst_ni);
    forever begin
      if (!hold_done && accepted_items >= HOLD_AFTER) begin
        hold_done = 1'b1;
        rdy = 1'b0;
        len = HOLD_CYCLES;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          rdy = 1'b1;
          len = $urandom_range(1, 20);
        end else if (r < 95) begin
          rdy = 1'b0;
          len = $urandom_range(1, 3);
        end else begin
          rdy = 1'b0;
          len = $urandom_range(15, 50);
        end
      end
      m_axis_tready <= rdy;
      repeat (len) @(posedge clk_i);
    end
  end

  initial begin
    int r;
    int idx;
    logic [63:0] pc;
    logic [63:0] tgt;
    logic tk;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Address extremes and the unsigned compare of the static
    // guess: equal addresses, all zeros against all ones, values on either side
    // of the top bit, and alternating bit patterns.
    send_branch(64'h0, 64'h0, 1'b0);
    send_branch(64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b1);
    send_branch(64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_branch(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_branch(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
    send_branch(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 1'b0);
    send_branch(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b1);
    send_branch(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);

    // One branch taken over and over drives its bimodal counter into the upper
    // limit, then not taken over and over into the lower one.
    for (int k = 0; k < 7; k++) begin
      send_branch(64'h0000_0000_0000_1234, 64'h0000_0000_0000_1000, 1'b1);
    end
    for (int k = 0; k < 7; k++) begin
      send_branch(64'h0000_0000_0000_1234, 64'h0000_0000_0000_1000, 1'b0);
    end

    // Same low address bits under different upper bits must share all table
    // entries; only the static guess sees the upper bits.
    send_branch(64'hDEAD_BEEF_0000_1234, 64'h0000_0000_0000_2000, 1'b1);
    send_branch(64'h1234_5678_9ABC_D234, 64'hFFFF_0000_0000_0000, 1'b1);

    for (int k = 0; k < POOL_SIZE; k++) begin
      pool_pc[k]    = {$urandom(), $urandom()};
      pool_tgt[k]   = {$urandom(), $urandom()};
      pool_pat[k]   = 16'($urandom());
      pool_len[k]   = $urandom_range(1, 12);
      pool_phase[k] = 0;
      // Some pool entries alias their neighbor in every table.
      if (k > 0 && $urandom_range(0, 3) == 0) begin
        pool_pc[k][9:0] = pool_pc[k-1][9:0];
      end
    end

    // Random part: mostly the recurring branches following their patterns
    // with an occasional flipped outcome, the rest fully random branches.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        idx = $urandom_range(0, POOL_SIZE - 1);
        pc  = pool_pc[idx];
        tgt = pool_tgt[idx];
        tk  = pool_pat[idx][pool_phase[idx]];
        if ($urandom_range(0, 99) < 7) begin
          tk = ~tk;
        end
        pool_phase[idx] = (pool_phase[idx] + 1) % pool_len[idx];
      end else begin
        pc  = {$urandom(), $urandom()};
        tgt = {$urandom(), $urandom()};
        tk  = 1'($urandom_range(0, 1));
      end
      send_branch(pc, tgt, tk);
    end
    s_axis_tvalid <= 1'b0;

    // Let the monitor see the last transfer before looking at what is still
    // owed, then drain and keep watching for anything unexpected.
    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
